// ----- hdl/pidmax_pkg.sv -----
`timescale 1ns / 1ps

package pidmax_pkg;

    localparam int ENTRIES    = 6;
    localparam int ID_W       = 22;
    localparam int TIME_W     = 63;
    localparam int SLOT_W     = 3;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 88;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_END   = 2'd1,
        CMD_EXIT  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               command;
        logic               from_user;
        logic               name_matches;
        logic [ID_W-1:0]    proc_id;
        logic [TIME_W-1:0]  timestamp;
        logic [SLOT_W-1:0]  slot;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic               new_max;
        logic               entry_valid;
        logic [ID_W-1:0]    entry_id;
        logic [TIME_W-1:0]  peak_ns;
    } result_t;

endpackage

// ----- hdl/pidmax_table.sv -----
`timescale 1ns / 1ps

module pidmax_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  pidmax_pkg::item_t  item,
    output pidmax_pkg::result_t result
);
    import pidmax_pkg::*;

    logic [ENTRIES-1:0] live_reg;
    logic [ID_W-1:0]    owner_reg   [ENTRIES];
    logic [TIME_W-1:0]  start_reg   [ENTRIES];
    logic [TIME_W-1:0]  longest_reg [ENTRIES];

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] slot_vec;
    logic [ENTRIES-1:0] tgt_vec;
    logic               hit_any;
    logic               free_any;
    logic [TIME_W-1:0]  hit_start;
    logic [TIME_W-1:0]  hit_longest;
    logic               rd_live;
    logic [ID_W-1:0]    rd_id;
    logic [TIME_W-1:0]  rd_longest;
    logic [TIME_W:0]    diff;
    logic               raise;
    logic               do_start;
    logic               do_alloc;
    logic               do_raise;
    logic               do_exit;

    // Parallel match over all slots; reads are one-hot AND-OR selects
    always_comb
    begin
        free_any    = 1'b0;
        hit_start   = '0;
        hit_longest = '0;
        rd_live     = 1'b0;
        rd_id       = '0;
        rd_longest  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]  = live_reg[i] && (owner_reg[i] == item.proc_id);
            // lowest-numbered free slot
            free_vec[i] = !live_reg[i] && !free_any;
            free_any    = free_any || !live_reg[i];
            slot_vec[i] = (32'(item.slot) == i);
            hit_start   = hit_start   | (start_reg[i]   & {TIME_W{hit_vec[i]}});
            hit_longest = hit_longest | (longest_reg[i] & {TIME_W{hit_vec[i]}});
            rd_live     = rd_live     | (live_reg[i] & slot_vec[i]);
            rd_id       = rd_id       | (owner_reg[i]   & {ID_W{slot_vec[i]}});
            rd_longest  = rd_longest  | (longest_reg[i] & {TIME_W{slot_vec[i]}});
        end
        hit_any = |hit_vec;
        tgt_vec = hit_any ? hit_vec : free_vec;
    end

    // Borrow bit set means now < start; zero difference is not positive either
    assign diff  = {1'b0, item.timestamp} - {1'b0, hit_start};
    assign raise = !diff[TIME_W] && (diff[TIME_W-1:0] != '0)
                   && (diff[TIME_W-1:0] > hit_longest);

    always_comb
    begin
        result   = '0;
        result.status = ST_IGNORED;
        do_start = 1'b0;
        do_alloc = 1'b0;
        do_raise = 1'b0;
        do_exit  = 1'b0;
        unique case (item.command)
            CMD_START:
            begin
                if (item.name_matches && item.from_user)
                begin
                    if (hit_any || free_any)
                    begin
                        do_start      = 1'b1;
                        do_alloc      = !hit_any;
                        result.status = ST_DONE;
                    end
                    else
                    begin
                        result.status = ST_FULL;
                    end
                end
            end
            CMD_END:
            begin
                if (item.name_matches && hit_any)
                begin
                    do_raise       = raise;
                    result.status  = ST_DONE;
                    result.new_max = raise;
                    result.peak_ns = raise ? diff[TIME_W-1:0] : hit_longest;
                end
            end
            CMD_EXIT:
            begin
                if (item.name_matches && hit_any)
                begin
                    do_exit       = 1'b1;
                    result.status = ST_DONE;
                end
            end
            CMD_READ:
            begin
                if (32'(item.slot) < ENTRIES)
                begin
                    result.status      = ST_DONE;
                    result.entry_valid = rd_live;
                    result.entry_id    = rd_id;
                    result.peak_ns     = rd_longest;
                end
            end
            default:
            begin
                result.status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                owner_reg[i]   <= '0;
                start_reg[i]   <= '0;
                longest_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (do_exit && hit_vec[i])
                begin
                    live_reg[i]    <= 1'b0;
                    owner_reg[i]   <= '0;
                    start_reg[i]   <= '0;
                    longest_reg[i] <= '0;
                end
                else
                begin
                    if (do_start && tgt_vec[i])
                    begin
                        start_reg[i] <= item.timestamp;
                        if (do_alloc)
                        begin
                            live_reg[i]    <= 1'b1;
                            owner_reg[i]   <= item.proc_id;
                            longest_reg[i] <= '0;
                        end
                    end
                    if (do_raise && hit_vec[i])
                    begin
                        longest_reg[i] <= diff[TIME_W-1:0];
                    end
                end
            end
        end
    end

endmodule

// ----- hdl/per_id_max_latency_table_top.sv -----
`timescale 1ns / 1ps
// Path: input register, then result register; the table lookup, subtract and compare
// sit in one stage between them; each accepted beat yields one result beat on m_axis.
// Throughput: one beat per cycle while m_axis does not stall.
// Reset (rst_n low, asynchronous): table slots cleared, both stages emptied.
// No post-reset sweep; beats are taken from the first cycle after reset.

module per_id_max_latency_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // from_user[0], name_matches[1], proc_id[23:2], timestamp[86:24], slot[89:87]
    input  logic [pidmax_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // new_max[0], entry_valid[1], entry_id[23:2], peak_ns[86:24]
    output logic [pidmax_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]                        m_axis_tuser
);
    import pidmax_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t result;
    logic    out_free;
    logic    fire;
    logic    s_beat;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_beat)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            item_reg.command      <= cmd_t'(s_axis_tuser);
            item_reg.from_user    <= s_axis_tdata[0];
            item_reg.name_matches <= s_axis_tdata[1];
            item_reg.proc_id      <= s_axis_tdata[23:2];
            item_reg.timestamp    <= s_axis_tdata[86:24];
            item_reg.slot         <= s_axis_tdata[89:87];
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    pidmax_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {1'b0, out_reg.peak_ns, out_reg.entry_id,
                            out_reg.entry_valid, out_reg.new_max};

endmodule

// ----- hdl/pidmax_checker.sv -----
`timescale 1ns / 1ps

module pidmax_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pidmax_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]                        m_axis_tuser
);
    import pidmax_pkg::*;

    logic       s_beat;
    logic       m_beat;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_beat = m_axis_tvalid && m_axis_tready;

    // beats taken in but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (s_beat && !m_beat)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!s_beat && m_beat)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_beat |-> (pend_reg != 2'd0))
        else $error("result beat without a pending input beat");

    a_two_deep: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more beats in flight than stages");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_DONE || m_axis_tuser == ST_IGNORED
                           || m_axis_tuser == ST_FULL))
        else $error("undefined status code");

    a_raise_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tuser == ST_DONE)
        && (m_axis_tdata[86:24] != '0))
        else $error("new maximum flagged on a failed or zero result");

endmodule

bind per_id_max_latency_table_top pidmax_checker u_pidmax_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pidmax_pkg::*;

    localparam logic [TIME_W-1:0] TS_MAX  = '1;
    localparam logic [ID_W-1:0]   ID_MAX  = '1;
    localparam int                RAND_ITEMS = 1625;
    localparam int                CALM_TAIL  = 150;

    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    // shadow copy of the table
    logic                   tbl_live    [ENTRIES];
    logic [ID_W-1:0]        tbl_owner   [ENTRIES];
    logic [TIME_W-1:0]      tbl_start   [ENTRIES];
    logic [TIME_W-1:0]      tbl_longest [ENTRIES];

    result_t                latency_expected_q[$];
    plan_row_t              plan_q[$];
    int                     mismatches;
    bit                     idle_on;
    logic [ID_W-1:0]        id_pool [8];
    logic [TIME_W-1:0]      clock_ns;

    per_id_max_latency_table_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("tb_top failed");
        $finish;
    end

    function automatic result_t latency_table_step(input item_t it);
        result_t          r;
        int               hit;
        int               fr;
        logic [TIME_W-1:0] span;
        r = '0;
        r.status = ST_IGNORED;
        hit = -1;
        fr = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && tbl_live[i] && tbl_owner[i] == it.proc_id)
                hit = i;
            if (fr < 0 && !tbl_live[i])
                fr = i;
        end
        case (it.command)
            CMD_START:
            begin
                if (it.name_matches && it.from_user)
                begin
                    if (hit < 0 && fr >= 0)
                    begin
                        hit = fr;
                        tbl_live[fr]    = 1'b1;
                        tbl_owner[fr]   = it.proc_id;
                        tbl_longest[fr] = '0;
                    end
                    if (hit >= 0)
                    begin
                        tbl_start[hit] = it.timestamp;
                        r.status = ST_DONE;
                    end
                    else
                        r.status = ST_FULL;
                end
            end
            CMD_END:
            begin
                if (it.name_matches && hit >= 0)
                begin
                    if (it.timestamp > tbl_start[hit])
                    begin
                        span = it.timestamp - tbl_start[hit];
                        if (span > tbl_longest[hit])
                        begin
                            tbl_longest[hit] = span;
                            r.new_max = 1'b1;
                        end
                    end
                    r.peak_ns = tbl_longest[hit];
                    r.status = ST_DONE;
                end
            end
            CMD_EXIT:
            begin
                if (it.name_matches && hit >= 0)
                begin
                    tbl_live[hit]    = 1'b0;
                    tbl_owner[hit]   = '0;
                    tbl_start[hit]   = '0;
                    tbl_longest[hit] = '0;
                    r.status = ST_DONE;
                end
            end
            default:
            begin
                if (it.slot < ENTRIES)
                begin
                    r.status      = ST_DONE;
                    r.entry_valid = tbl_live[it.slot];
                    r.entry_id    = tbl_owner[it.slot];
                    r.peak_ns     = tbl_longest[it.slot];
                end
            end
        endcase
        return r;
    endfunction

    function automatic item_t make_item(cmd_t cmd, logic user, logic match,
                                        logic [ID_W-1:0] id, logic [TIME_W-1:0] ts,
                                        logic [SLOT_W-1:0] slot);
        item_t it;
        it.command      = cmd;
        it.from_user    = user;
        it.name_matches = match;
        it.proc_id      = id;
        it.timestamp    = ts;
        it.slot         = slot;
        return it;
    endfunction

    function automatic void add_row(item_t it, bit typed, result_t want);
        plan_row_t pr;
        pr.beat  = it;
        pr.typed = typed;
        pr.want  = want;
        plan_q.push_back(pr);
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            it.command = CMD_START;
        else if (pick < 70)
            it.command = CMD_END;
        else if (pick < 80)
            it.command = CMD_EXIT;
        else
            it.command = CMD_READ;
        it.from_user    = ($urandom_range(0, 9) != 0);
        it.name_matches = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) == 0)
            it.proc_id = ID_W'($urandom);
        else
            it.proc_id = id_pool[3'($urandom_range(0, 7))];
        clock_ns = clock_ns + $urandom_range(0, 5000);
        pick = $urandom_range(0, 39);
        if (pick == 0)
            it.timestamp = TIME_W'({$urandom, $urandom});
        else if (pick < 3)
            it.timestamp = clock_ns - $urandom_range(0, 20000);   // clock stepping back
        else
            it.timestamp = clock_ns;
        it.slot = SLOT_W'($urandom_range(0, 7));
        return it;
    endfunction

    // one beat into the block; the expectation is queued on acceptance
    task automatic send_beat(input item_t it, input bit typed, input result_t want);
        result_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.slot, it.timestamp, it.proc_id,
                          it.name_matches, it.from_user};
        s_axis_tuser  <= it.command;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = latency_table_step(it);
        latency_expected_q.push_back(typed ? want : r);
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (latency_expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("mismatch %s: expected %h got %h at %0t", name, want, got, $realtime);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (latency_expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat at %0t", $realtime);
                mismatches++;
            end
            else
            begin
                want = latency_expected_q.pop_front();
                note_field("status",      want.status,      m_axis_tuser);
                note_field("new_max",     want.new_max,     m_axis_tdata[0]);
                note_field("entry_valid", want.entry_valid, m_axis_tdata[1]);
                note_field("entry_id",    want.entry_id,    m_axis_tdata[23:2]);
                note_field("peak_ns",     want.peak_ns,     m_axis_tdata[86:24]);
            end
        end
    end

    // result side backpressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rst_n         = 1'b0;
        mismatches    = 0;
        idle_on       = 1'b1;
        clock_ns      = TIME_W'({$urandom, $urandom} >> 2);
        for (int i = 0; i < 8; i++)
            id_pool[i] = ID_W'($urandom);
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_live[i]    = 1'b0;
            tbl_owner[i]   = '0;
            tbl_start[i]   = '0;
            tbl_longest[i] = '0;
        end

        // directed part
        add_row(make_item(CMD_READ, 0, 0, 0, 0, 0), 1, '{ST_DONE, 0, 0, 0, 0});
        add_row(make_item(CMD_READ, 1, 1, ID_MAX, TS_MAX, 7), 1, '{ST_IGNORED, 0, 0, 0, 0});
        add_row(make_item(CMD_START, 1, 0, 9, 100, 0), 1, '{ST_IGNORED, 0, 0, 0, 0});
        add_row(make_item(CMD_START, 0, 1, 9, 100, 0), 1, '{ST_IGNORED, 0, 0, 0, 0});
        add_row(make_item(CMD_END, 1, 1, 9, 200, 0), 1, '{ST_IGNORED, 0, 0, 0, 0});
        add_row(make_item(CMD_EXIT, 1, 1, 9, 0, 0), 1, '{ST_IGNORED, 0, 0, 0, 0});
        add_row(make_item(CMD_START, 1, 1, ID_MAX, 0, 0), 1, '{ST_DONE, 0, 0, 0, 0});
        add_row(make_item(CMD_END, 0, 1, ID_MAX, TS_MAX, 0), 1,
                '{ST_DONE, 1, 0, 0, TS_MAX});
        add_row(make_item(CMD_READ, 0, 0, 0, 0, 0), 1, '{ST_DONE, 0, 1, ID_MAX, TS_MAX});
        add_row(make_item(CMD_END, 1, 1, ID_MAX, 5, 4), 0, '0);
        add_row(make_item(CMD_START, 1, 1, 0, TS_MAX, 0), 0, '0);
        // end before start time: nothing raised
        add_row(make_item(CMD_END, 1, 1, 0, 0, 0), 1, '{ST_DONE, 0, 0, 0, 0});
        add_row(make_item(CMD_START, 1, 1, 1, 1000, 0), 0, '0);
        add_row(make_item(CMD_START, 1, 1, 2, 2000, 0), 0, '0);
        add_row(make_item(CMD_START, 1, 1, 3, 3000, 0), 0, '0);
        add_row(make_item(CMD_START, 1, 1, 4, 4000, 0), 0, '0);
        add_row(make_item(CMD_START, 1, 1, 5, 5000, 0), 1, '{ST_FULL, 0, 0, 0, 0});
        add_row(make_item(CMD_EXIT, 1, 1, ID_MAX, 0, 0), 0, '0);
        add_row(make_item(CMD_READ, 1, 1, 0, 0, 0), 1, '{ST_DONE, 0, 0, 0, 0});
        add_row(make_item(CMD_START, 1, 1, 5, 6000, 0), 0, '0);
        add_row(make_item(CMD_END, 1, 1, 3, 9000, 0), 0, '0);
        add_row(make_item(CMD_END, 1, 0, 3, 99000, 0), 1, '{ST_IGNORED, 0, 0, 0, 0});
        add_row(make_item(CMD_EXIT, 1, 0, 3, 0, 0), 1, '{ST_IGNORED, 0, 0, 0, 0});
        add_row(make_item(CMD_START, 1, 1, 3, 10000, 0), 0, '0);
        add_row(make_item(CMD_READ, 0, 1, 0, 0, 5), 0, '0);
        add_row(make_item(CMD_READ, 1, 0, 0, 0, 6), 1, '{ST_IGNORED, 0, 0, 0, 0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            send_beat(plan_q[i].beat, plan_q[i].typed, plan_q[i].want);
            maybe_gap();
        end
        drain();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 300 == 299)
                id_pool[3'($urandom_range(0, 7))] = ID_W'($urandom);
            if (n == RAND_ITEMS / 2)
                drain();
            if (n == RAND_ITEMS - CALM_TAIL)
                idle_on = 1'b0;
            send_beat(random_item(), 0, '0);
            maybe_gap();
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && latency_expected_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
